/* rtl/spu_pkg.sv */
// Shared types and constants for the swarm particle position update pipeline.
package spu_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_INERTIA   = 2'd0;
    localparam logic [1:0] REG_SOCIAL    = 2'd1;
    localparam logic [1:0] REG_COGNITIVE = 2'd2;
    localparam logic [1:0] REG_FRACTION  = 2'd3;

    // Reset values of the configuration registers
    localparam logic [15:0] INERTIA_RESET   = 16'd2048;
    localparam logic [15:0] SOCIAL_RESET    = 16'd8192;
    localparam logic [15:0] COGNITIVE_RESET = 16'd6144;
    localparam logic [15:0] FRACTION_RESET  = 16'd9830;

    // Boundary case codes
    localparam logic [1:0] BC_INSIDE = 2'd0;
    localparam logic [1:0] BC_BELOW  = 2'd1;
    localparam logic [1:0] BC_ABOVE  = 2'd2;

    // Reciprocals for division by 100 (31-bit operand) and by 10 (31-bit operand)
    localparam logic [31:0] RECIP_100 = 32'd2748779070;
    localparam int          SHIFT_100 = 38;
    localparam logic [30:0] RECIP_10  = 31'd1717986919;
    localparam int          SHIFT_10  = 34;

    // Register stages from an accepted start to its done strobe
    localparam int PIPE_DEPTH = 5;

    // Clamped step handed from the step stages to the reflection stages
    typedef struct packed {
        logic               valid;
        logic signed [31:0] x;
        logic        [30:0] b;
        logic signed [31:0] step;
        logic               limited;
    } spu_step_t;

endpackage

/* rtl/swarm_particle_position_update.sv */
// Top level of the swarm particle position and velocity update pipeline.
//
//  channel   handshake            payload
//  input     start (busy low)     position velocity personal_best global_best
//                                 upper_bound rand_social rand_cognitive
//  result    done, one cycle      new_position new_velocity boundary_case step_limited
//  config    cfg_write            cfg_index cfg_data
//
// One transaction enters per clock; busy stays low, as the pipeline never backs up.
// Three stages form and clamp the step (weights, products, sum), and two further stages
// apply it (reciprocal divides, select).
// Reset clears the stage valid bits and loads the default weights.
// The receiver cannot stall, so results leave the last stage as they arrive.
module swarm_particle_position_update
    import spu_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] position,
    input  logic signed [31:0] velocity,
    input  logic signed [31:0] personal_best,
    input  logic signed [31:0] global_best,
    input  logic        [30:0] upper_bound,
    input  logic        [15:0] rand_social,
    input  logic        [15:0] rand_cognitive,
    output logic               done,
    output logic signed [31:0] new_position,
    output logic signed [31:0] new_velocity,
    output logic        [1:0]  boundary_case,
    output logic               step_limited,
    input  logic               cfg_write,
    input  logic        [1:0]  cfg_index,
    input  logic        [15:0] cfg_data
);

    localparam int VW         = (VALUE_WIDTH > 32) ? 32 : ((VALUE_WIDTH < 16) ? 16 : VALUE_WIDTH);
    localparam int SEXT_SHIFT = 32 - VW;

    logic [15:0] inertia_reg, social_reg, cognitive_reg, fraction_reg;
    logic [15:0] inertia_next, social_next, cognitive_next, fraction_next;

    always_comb
    begin
        inertia_next   = inertia_reg;
        social_next    = social_reg;
        cognitive_next = cognitive_reg;
        fraction_next  = fraction_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_INERTIA:   inertia_next   = cfg_data;
                REG_SOCIAL:    social_next    = cfg_data;
                REG_COGNITIVE: cognitive_next = cfg_data;
                REG_FRACTION:  fraction_next  = cfg_data;
                default:       inertia_next   = inertia_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inertia_reg   <= INERTIA_RESET;
            social_reg    <= SOCIAL_RESET;
            cognitive_reg <= COGNITIVE_RESET;
            fraction_reg  <= FRACTION_RESET;
        end
        else
        begin
            inertia_reg   <= inertia_next;
            social_reg    <= social_next;
            cognitive_reg <= cognitive_next;
            fraction_reg  <= fraction_next;
        end
    end

    // Sign-extend the value fields from the configured value width
    logic signed [31:0] x_shl, v_shl, p_shl, g_shl;
    logic signed [31:0] x_ext, v_ext, p_ext, g_ext;

    assign x_shl = position <<< SEXT_SHIFT;
    assign v_shl = velocity <<< SEXT_SHIFT;
    assign p_shl = personal_best <<< SEXT_SHIFT;
    assign g_shl = global_best <<< SEXT_SHIFT;
    assign x_ext = x_shl >>> SEXT_SHIFT;
    assign v_ext = v_shl >>> SEXT_SHIFT;
    assign p_ext = p_shl >>> SEXT_SHIFT;
    assign g_ext = g_shl >>> SEXT_SHIFT;

    assign busy = 1'b0;

    spu_step_t step_bus;

    spu_step_calc u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .x         (x_ext),
        .v         (v_ext),
        .p         (p_ext),
        .g         (g_ext),
        .b         (upper_bound),
        .r1        (rand_social),
        .r2        (rand_cognitive),
        .inertia   (inertia_reg),
        .social    (social_reg),
        .cognitive (cognitive_reg),
        .fraction  (fraction_reg),
        .step_out  (step_bus)
    );

    spu_reflect #(
        .SAT_WIDTH (VW)
    ) u_reflect (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_in       (step_bus),
        .done          (done),
        .new_position  (new_position),
        .new_velocity  (new_velocity),
        .boundary_case (boundary_case),
        .step_limited  (step_limited)
    );

endmodule

/* rtl/spu_step_calc.sv */
// Three-stage pipeline forming the clamped step from position, velocity and bests.
module spu_step_calc
    import spu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [31:0] x,
    input  logic signed [31:0] v,
    input  logic signed [31:0] p,
    input  logic signed [31:0] g,
    input  logic        [30:0] b,
    input  logic        [15:0] r1,
    input  logic        [15:0] r2,
    input  logic        [15:0] inertia,
    input  logic        [15:0] social,
    input  logic        [15:0] cognitive,
    input  logic        [15:0] fraction,
    output spu_step_t          step_out
);

    // Stage 1: random factors, differences, step limit
    logic               s1_valid_reg;
    logic signed [31:0] s1_x_reg, s1_v_reg;
    logic signed [32:0] s1_dg_reg, s1_dp_reg;
    logic        [15:0] s1_cs_reg, s1_cc_reg;
    logic        [30:0] s1_b_reg, s1_lim_reg;

    logic        [31:0] cs_prod, cc_prod;
    logic        [46:0] lim_prod;
    logic signed [32:0] s1_dg_next, s1_dp_next;

    assign cs_prod    = social * r1;
    assign cc_prod    = cognitive * r2;
    assign lim_prod   = fraction * b;
    assign s1_dg_next = 33'(g) - 33'(x);
    assign s1_dp_next = 33'(p) - 33'(x);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_x_reg   <= x;
        s1_v_reg   <= v;
        s1_dg_reg  <= s1_dg_next;
        s1_dp_reg  <= s1_dp_next;
        s1_cs_reg  <= cs_prod[31:16];
        s1_cc_reg  <= cc_prod[31:16];
        s1_b_reg   <= b;
        s1_lim_reg <= lim_prod[46:16];
    end

    // Stage 2: the three weighted terms
    logic               s2_valid_reg;
    logic signed [31:0] s2_x_reg;
    logic        [30:0] s2_b_reg, s2_lim_reg;
    logic signed [48:0] s2_pi_reg;
    logic signed [49:0] s2_ps_reg, s2_pc_reg;

    logic signed [16:0] w_in, w_soc, w_cog;
    logic signed [48:0] s2_pi_next;
    logic signed [49:0] s2_ps_next, s2_pc_next;

    assign w_in       = signed'({1'b0, inertia});
    assign w_soc      = signed'({1'b0, s1_cs_reg});
    assign w_cog      = signed'({1'b0, s1_cc_reg});
    assign s2_pi_next = w_in * s1_v_reg;
    assign s2_ps_next = w_soc * s1_dg_reg;
    assign s2_pc_next = w_cog * s1_dp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_x_reg   <= s1_x_reg;
        s2_b_reg   <= s1_b_reg;
        s2_lim_reg <= s1_lim_reg;
        s2_pi_reg  <= s2_pi_next;
        s2_ps_reg  <= s2_ps_next;
        s2_pc_reg  <= s2_pc_next;
    end

    // Stage 3: sum, floor shift to Q16.16, clamp to the limit
    spu_step_t          s3_reg, s3_next;
    logic signed [51:0] acc;
    logic signed [39:0] step_full, lim_pos, lim_neg;

    assign acc       = 52'(s2_pi_reg) + 52'(s2_ps_reg) + 52'(s2_pc_reg);
    assign step_full = acc[51:12];
    assign lim_pos   = signed'({9'd0, s2_lim_reg});
    assign lim_neg   = -lim_pos;

    always_comb
    begin
        s3_next.valid   = s2_valid_reg;
        s3_next.x       = s2_x_reg;
        s3_next.b       = s2_b_reg;
        s3_next.limited = 1'b0;
        s3_next.step    = step_full[31:0];
        if (step_full > lim_pos)
        begin
            s3_next.step    = lim_pos[31:0];
            s3_next.limited = 1'b1;
        end
        else if (step_full < lim_neg)
        begin
            s3_next.step    = lim_neg[31:0];
            s3_next.limited = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_reg <= '0;
        end
        else
        begin
            s3_reg <= s3_next;
        end
    end

    assign step_out = s3_reg;

endmodule

/* rtl/spu_reflect.sv */
// Two-stage pipeline applying the step, reflecting at the bounds and saturating.
module spu_reflect
    import spu_pkg::*;
#(
    parameter int SAT_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  spu_step_t          step_in,
    output logic               done,
    output logic signed [31:0] new_position,
    output logic signed [31:0] new_velocity,
    output logic        [1:0]  boundary_case,
    output logic               step_limited
);

    localparam logic signed [32:0] SAT_HI = (33'sd1 <<< (SAT_WIDTH - 1)) - 33'sd1;
    localparam logic signed [32:0] SAT_LO = -SAT_HI - 33'sd1;

    // Stage 4: candidate position and the two reciprocal products
    logic               s4_valid_reg;
    logic signed [32:0] s4_sum_reg;
    logic signed [31:0] s4_step_reg;
    logic        [30:0] s4_b_reg;
    logic               s4_neg_reg, s4_lim_reg;
    logic        [61:0] s4_q10_reg;
    logic        [62:0] s4_q100_reg;

    logic signed [32:0] s4_sum_next;
    logic        [31:0] step_abs;
    logic        [61:0] s4_q10_next;
    logic        [62:0] s4_q100_next;

    assign s4_sum_next  = 33'(step_in.x) + 33'(step_in.step);
    assign step_abs     = step_in.step[31] ? 32'(-step_in.step) : 32'(step_in.step);
    assign s4_q10_next  = step_abs[30:0] * RECIP_10;
    assign s4_q100_next = step_in.b * RECIP_100;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= step_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_sum_reg  <= s4_sum_next;
        s4_step_reg <= step_in.step;
        s4_b_reg    <= step_in.b;
        s4_neg_reg  <= step_in.step[31];
        s4_lim_reg  <= step_in.limited;
        s4_q10_reg  <= s4_q10_next;
        s4_q100_reg <= s4_q100_next;
    end

    // Stage 5: choose the case and saturate
    logic               done_reg;
    logic signed [31:0] pos_reg, vel_reg;
    logic        [1:0]  bc_reg;
    logic               lim_reg;

    logic        [27:0] q10;
    logic        [24:0] q100;
    logic signed [32:0] bounce_vel, np_raw, nv_raw;
    logic signed [31:0] pos_next, vel_next;
    logic        [1:0]  bc_next;

    assign q10        = s4_q10_reg[61:SHIFT_10];
    assign q100       = s4_q100_reg[62:SHIFT_100];
    // velocity reverses: minus the step divided by ten, truncated toward zero
    assign bounce_vel = s4_neg_reg ? signed'({5'd0, q10}) : -signed'({5'd0, q10});

    always_comb
    begin
        if (s4_sum_reg < 33'sd0)
        begin
            np_raw  = signed'({8'd0, q100});
            nv_raw  = bounce_vel;
            bc_next = BC_BELOW;
        end
        else if (s4_sum_reg > signed'({2'b00, s4_b_reg}))
        begin
            np_raw  = signed'({2'b00, s4_b_reg});
            nv_raw  = bounce_vel;
            bc_next = BC_ABOVE;
        end
        else
        begin
            np_raw  = s4_sum_reg;
            nv_raw  = 33'(s4_step_reg);
            bc_next = BC_INSIDE;
        end

        if (np_raw > SAT_HI)
            pos_next = SAT_HI[31:0];
        else if (np_raw < SAT_LO)
            pos_next = SAT_LO[31:0];
        else
            pos_next = np_raw[31:0];

        if (nv_raw > SAT_HI)
            vel_next = SAT_HI[31:0];
        else if (nv_raw < SAT_LO)
            vel_next = SAT_LO[31:0];
        else
            vel_next = nv_raw[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        vel_reg <= vel_next;
        bc_reg  <= bc_next;
        lim_reg <= s4_lim_reg;
    end

    assign done          = done_reg;
    assign new_position  = pos_reg;
    assign new_velocity  = vel_reg;
    assign boundary_case = bc_reg;
    assign step_limited  = lim_reg;

endmodule

/* rtl/spu_checker.sv */
// Port-level checks on the swarm particle position update, bound to the top level.
module spu_checker
    import spu_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [31:0] new_position,
    input logic        [1:0]  boundary_case
);

    // Every accepted transaction yields a result after the pipeline depth
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_DEPTH done)
        else $error("accepted transaction produced no result");

    // No result without a transaction accepted the pipeline depth before
    a_latency_rev: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_DEPTH))
        else $error("result without a matching transaction");

    // The new position of every result is never below zero
    a_pos_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !new_position[31])
        else $error("new position below zero");

    a_bc_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (boundary_case == BC_INSIDE || boundary_case == BC_BELOW
                  || boundary_case == BC_ABOVE))
        else $error("undefined boundary case");

endmodule

bind swarm_particle_position_update spu_checker u_spu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .new_position  (new_position),
    .boundary_case (boundary_case)
);

/* test/tb_top.sv */
// Self-checking testbench for the swarm particle position update pipeline.
`timescale 1ns / 100ps

module tb_top
    import spu_pkg::*;
;

    localparam logic [31:0] ONE           = 32'h0001_0000;
    localparam int          IDLE_PERCENT  = 38;
    localparam int          STALL_LIMIT   = 2000;
    localparam int          RANDOM_PER_SET = 300;

    typedef struct packed {
        logic [31:0] position;
        logic [31:0] velocity;
        logic [31:0] personal_best;
        logic [31:0] global_best;
        logic [30:0] upper_bound;
        logic [15:0] rand_social;
        logic [15:0] rand_cognitive;
    } particle_dim_t;

    typedef struct packed {
        logic [31:0] new_position;
        logic [31:0] new_velocity;
        logic [1:0]  boundary_case;
        logic        step_limited;
    } dim_update_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] position = '0;
    logic [31:0] velocity = '0;
    logic [31:0] personal_best = '0;
    logic [31:0] global_best = '0;
    logic [30:0] upper_bound = '0;
    logic [15:0] rand_social = '0;
    logic [15:0] rand_cognitive = '0;
    logic        done;
    logic [31:0] new_position;
    logic [31:0] new_velocity;
    logic [1:0]  boundary_case;
    logic        step_limited;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = REG_INERTIA;
    logic [15:0] cfg_data = '0;

    // Weights as the block holds them
    logic [15:0] inertia_w   = INERTIA_RESET;
    logic [15:0] social_w    = SOCIAL_RESET;
    logic [15:0] cognitive_w = COGNITIVE_RESET;
    logic [15:0] fraction_w  = FRACTION_RESET;

    particle_dim_t pending_dims[$];
    dim_update_t   expected_updates[$];

    logic no_idle = 1'b0;
    int   mismatches = 0;
    int   dims_sent = 0;
    int   updates_checked = 0;
    int   weight_sets = 1;
    int   case_count[3] = '{0, 0, 0};
    int   clamped_count = 0;
    int   stall_cycles = 0;

    swarm_particle_position_update i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .position      (position),
        .velocity      (velocity),
        .personal_best (personal_best),
        .global_best   (global_best),
        .upper_bound   (upper_bound),
        .rand_social   (rand_social),
        .rand_cognitive(rand_cognitive),
        .done          (done),
        .new_position  (new_position),
        .new_velocity  (new_velocity),
        .boundary_case (boundary_case),
        .step_limited  (step_limited),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] clamp32(longint val);
        if (val > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (val < -64'sd2147483648)
            return 32'h8000_0000;
        return val[31:0];
    endfunction

    function automatic dim_update_t predict_update(particle_dim_t d);
        longint x, v, p, g, b, r1, r2;
        longint wi, ws, wc, frac, cs, cc, acc, step, lim, sum, np, nv;
        dim_update_t u;
        x = longint'($signed(d.position));
        v = longint'($signed(d.velocity));
        p = longint'($signed(d.personal_best));
        g = longint'($signed(d.global_best));
        b = longint'(d.upper_bound);
        r1 = longint'(d.rand_social);
        r2 = longint'(d.rand_cognitive);
        wi = longint'(inertia_w);
        ws = longint'(social_w);
        wc = longint'(cognitive_w);
        frac = longint'(fraction_w);
        cs = (ws * r1) >>> 16;
        cc = (wc * r2) >>> 16;
        acc = wi * v + cs * (g - x) + cc * (p - x);
        step = acc >>> 12;
        lim = (frac * b) >>> 16;
        u.step_limited = 1'b0;
        if (step > lim)
        begin
            step = lim;
            u.step_limited = 1'b1;
        end
        else if (step < -lim)
        begin
            step = -lim;
            u.step_limited = 1'b1;
        end
        sum = x + step;
        // Reflect off either wall with a tenth of the step reversed
        if (sum < 0)
        begin
            np = b / 100;
            nv = -(step / 10);
            u.boundary_case = BC_BELOW;
        end
        else if (sum > b)
        begin
            np = b;
            nv = -(step / 10);
            u.boundary_case = BC_ABOVE;
        end
        else
        begin
            np = sum;
            nv = step;
            u.boundary_case = BC_INSIDE;
        end
        u.new_position = clamp32(np);
        u.new_velocity = clamp32(nv);
        return u;
    endfunction

    function automatic particle_dim_t random_dim();
        particle_dim_t d;
        int unsigned kind;
        longint b, x, v, p, g, span;
        kind = $urandom_range(99);
        case ($urandom_range(3))
            0: b = longint'($urandom_range(255));
            1: b = longint'($urandom_range(32'h000F_FFFF));
            2: b = longint'($urandom_range(32'h0FFF_FFFF));
            default: b = longint'($urandom & 32'h7FFF_FFFF);
        endcase
        if (kind < 60)
        begin
            // Particle inside its range, bests inside too
            x = longint'($urandom_range(32'(b)));
            p = longint'($urandom_range(32'(b)));
            g = longint'($urandom_range(32'(b)));
            v = longint'($urandom_range(32'(b / 2))) - b / 4;
        end
        else if (kind < 80)
        begin
            // Hug one wall and push hard
            span = b / 16;
            x = $urandom_range(1) ? longint'($urandom_range(32'(span)))
                                  : b - longint'($urandom_range(32'(span)));
            p = longint'($urandom_range(32'(b)));
            g = longint'($urandom_range(32'(b)));
            v = longint'($urandom_range(32'(b))) - b / 2;
        end
        else
        begin
            x = longint'($urandom);
            p = longint'($urandom);
            g = longint'($urandom);
            v = longint'($urandom);
            b = longint'($urandom);
        end
        d.position = x[31:0];
        d.velocity = v[31:0];
        d.personal_best = p[31:0];
        d.global_best = g[31:0];
        d.upper_bound = b[30:0];
        d.rand_social = 16'($urandom_range(16'hFFFF));
        d.rand_cognitive = 16'($urandom_range(16'hFFFF));
        return d;
    endfunction

    task automatic queue_dim(logic [31:0] x, logic [31:0] v, logic [31:0] p, logic [31:0] g,
                             logic [31:0] b, logic [15:0] r1, logic [15:0] r2);
        particle_dim_t d;
        d = '{x, v, p, g, b[30:0], r1, r2};
        pending_dims.push_back(d);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic write_register(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_INERTIA:   inertia_w = val;
            REG_SOCIAL:    social_w = val;
            REG_COGNITIVE: cognitive_w = val;
            REG_FRACTION:  fraction_w = val;
        endcase
    endtask

    task automatic apply_weights(logic [15:0] wi, logic [15:0] ws, logic [15:0] wc,
                                 logic [15:0] fr);
        write_register(REG_INERTIA, wi);
        write_register(REG_SOCIAL, ws);
        write_register(REG_COGNITIVE, wc);
        write_register(REG_FRACTION, fr);
        weight_sets++;
    endtask

    task automatic run_random(int count);
        @(negedge clk);
        repeat (count) pending_dims.push_back(random_dim());
        while (pending_dims.size() != 0 || expected_updates.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    // Driver: present the head of the pending queue, drop it once accepted
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_updates.push_back(predict_update(pending_dims[0]));
                pending_dims.delete(0);
                dims_sent++;
            end
            if (!start || !busy)
            begin
                if (pending_dims.size() != 0 &&
                    (no_idle || $urandom_range(99) >= IDLE_PERCENT))
                begin
                    start <= 1'b1;
                    position <= pending_dims[0].position;
                    velocity <= pending_dims[0].velocity;
                    personal_best <= pending_dims[0].personal_best;
                    global_best <= pending_dims[0].global_best;
                    upper_bound <= pending_dims[0].upper_bound;
                    rand_social <= pending_dims[0].rand_social;
                    rand_cognitive <= pending_dims[0].rand_cognitive;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobe takes the oldest expectation
    always @(posedge clk)
    begin
        dim_update_t want;
        if (rst_n && done)
        begin
            if (expected_updates.size() == 0)
            begin
                report_mismatch("unexpected transaction", new_position, '0);
            end
            else
            begin
                want = expected_updates.pop_front();
                if (new_position !== want.new_position)
                    report_mismatch("new_position", new_position, want.new_position);
                if (new_velocity !== want.new_velocity)
                    report_mismatch("new_velocity", new_velocity, want.new_velocity);
                if (boundary_case !== want.boundary_case)
                    report_mismatch("boundary_case", 32'(boundary_case),
                                    32'(want.boundary_case));
                if (step_limited !== want.step_limited)
                    report_mismatch("step_limited", 32'(step_limited),
                                    32'(want.step_limited));
                if (want.boundary_case <= BC_ABOVE)
                    case_count[want.boundary_case]++;
                if (want.step_limited)
                    clamped_count++;
                updates_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || cfg_write)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Timed out after %0d cycles without a transaction", STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default weights: walls, clamping edges, rounding and field extremes
        @(negedge clk);
        queue_dim('0, '0, '0, '0, '0, '0, '0);
        queue_dim(50 * ONE, ONE, 50 * ONE, 50 * ONE, 100 * ONE, '0, '0);
        queue_dim(50 * ONE, '0, 50 * ONE, 60 * ONE, 100 * ONE, 16'hFFFF, '0);
        queue_dim(50 * ONE, '0, 40 * ONE, 50 * ONE, 100 * ONE, '0, 16'hFFFF);
        queue_dim(99 * ONE, 40 * ONE, 99 * ONE, 99 * ONE, 100 * ONE, '0, '0);
        queue_dim(ONE, -(40 * ONE), ONE, ONE, 100 * ONE, '0, '0);
        queue_dim(32768, 19660, 32768, 32768, 65536, '0, '0);
        queue_dim(32768, 19662, 32768, 32768, 65536, '0, '0);
        queue_dim(32768, -19660, 32768, 32768, 65536, '0, '0);
        queue_dim(32768, -19662, 32768, 32768, 65536, '0, '0);
        queue_dim(10 * ONE, -3, 10 * ONE, 10 * ONE, 100 * ONE, '0, '0);
        queue_dim('0, -30, '0, '0, 100 * ONE, '0, '0);
        queue_dim(100 * ONE, '0, 100 * ONE, 100 * ONE, 100 * ONE, '0, '0);
        queue_dim(32'hFFFF_FFFF, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 100 * ONE, '0, '0);
        queue_dim(100 * ONE + 1, '0, 100 * ONE + 1, 100 * ONE + 1, 100 * ONE, '0, '0);
        queue_dim(5, '0, 5, 5, '0, '0, '0);
        queue_dim(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF);
        queue_dim(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  '0, 16'hFFFF, 16'hFFFF);
        queue_dim(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF);
        queue_dim(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, '0, '0);
        queue_dim(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF);
        run_random(RANDOM_PER_SET);

        apply_weights('0, '0, '0, '0);
        run_random(RANDOM_PER_SET);

        apply_weights(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(RANDOM_PER_SET);

        apply_weights(16'h1000, 16'h0800, 16'h0400, 16'hFFFF);
        run_random(RANDOM_PER_SET);

        // Back-to-back transactions with no gaps
        apply_weights(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        no_idle = 1'b1;
        run_random(RANDOM_PER_SET);
        no_idle = 1'b0;

        apply_weights(16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom_range(16'h3FFF)));
        run_random(RANDOM_PER_SET);

        if (expected_updates.size() != 0)
            report_mismatch("outstanding expectations", expected_updates.size(), '0);

        $display("Checked %0d of %0d transactions over %0d weight sets", updates_checked,
                 dims_sent, weight_sets);
        $display("Inside %0d, below zero %0d, above bound %0d, step clamped %0d; %0d mismatches",
                 case_count[BC_INSIDE], case_count[BC_BELOW], case_count[BC_ABOVE],
                 clamped_count, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/spu_pkg.sv
rtl/spu_step_calc.sv
rtl/spu_reflect.sv
rtl/swarm_particle_position_update.sv
rtl/spu_checker.sv
test/tb_top.sv
